// ----- design/integer_to_digit_string_defines.svh -----
// assertion macros shared by the integer to digit string design
`ifndef INTEGER_TO_DIGIT_STRING_DEFINES_SVH
`define INTEGER_TO_DIGIT_STRING_DEFINES_SVH

// implication checked in the same cycle
`define ITOA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/itoa_pkg.sv -----
// types, constants and helpers for the integer to digit string design
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int NUMBER_BITS    = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int VALUE_MIN      = 8;
  localparam int VALUE_MAX      = 32;
  localparam int STEP_BITS      = 8;
  localparam int DIGIT_BITS     = 4;
  localparam int RADIX_BITS     = 5;
  localparam int CHAR_BITS      = 7;
  localparam int LEN_BITS       = 6;
  localparam int STORE_DEPTH    = 32;
  localparam int IDX_BITS       = $clog2(STORE_DEPTH);

  typedef logic [DIGIT_BITS-1:0] digit_t;
  typedef logic [RADIX_BITS-1:0] radix_t;
  typedef logic [CHAR_BITS-1:0]  char_t;
  typedef logic [LEN_BITS-1:0]   len_t;

  localparam radix_t RADIX_MIN   = 5'd2;
  localparam radix_t RADIX_MAX   = 5'd16;
  localparam radix_t RADIX_DEC   = 5'd10;
  localparam radix_t RADIX_RESET = RADIX_DEC;

  localparam digit_t DIGIT_TEN = 4'd10;

  localparam char_t CHAR_ZERO  = 7'h30;
  localparam char_t CHAR_UPPER = 7'h41;
  localparam char_t CHAR_MINUS = 7'h2D;

  function automatic char_t char_of_digit(digit_t d);
    if (d < DIGIT_TEN) begin
      return char_t'(CHAR_ZERO + char_t'(d));
    end
    return char_t'(CHAR_UPPER + char_t'(d - DIGIT_TEN));
  endfunction

endpackage

// ----- design/itoa_div_step.sv -----
// shared divide unit: one byte of long division by a small base
`timescale 1ns / 1ps

module itoa_div_step
  import itoa_pkg::*;
(
  input  digit_t               rem_in,
  input  logic [STEP_BITS-1:0] bits_in,
  input  radix_t               divisor,
  output logic [STEP_BITS-1:0] quot_out,
  output digit_t               rem_out
);

  always_comb begin
    logic [RADIX_BITS-1:0] part;
    logic [STEP_BITS-1:0]  q;
    part = RADIX_BITS'(rem_in);
    q    = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      part = {part[RADIX_BITS-2:0], bits_in[i]};
      if (part >= divisor) begin
        part = part - divisor;
        q[i] = 1'b1;
      end
    end
    quot_out = q;
    rem_out  = part[DIGIT_BITS-1:0];
  end

endmodule

// ----- design/integer_to_digit_string.sv -----
// top level: integer to ascii digit string converter in a base of 2 to 16
//
// channel   ports                                        handshake
// input     start, busy, in_number                       start && !busy
// result    out_valid, out_char_code, out_is_last,       out_valid strobe
//           out_text_length
// config    cfg_valid, cfg_ready, cfg_radix              cfg_valid && cfg_ready
//
// one transaction emits D digit characters and S sign characters
// the shared divide unit handles 8 quotient bits per cycle, a digit per pass
// synchronous active-low reset, radix resets to ten, no clearing pass
// results are strobed for one cycle each; the receiver cannot stall
`timescale 1ns / 1ps
`include "integer_to_digit_string_defines.svh"

module integer_to_digit_string
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
)(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [RADIX_BITS-1:0]         cfg_radix,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [NUMBER_BITS-1:0] in_number,
  output logic                          out_valid,
  output logic [CHAR_BITS-1:0]          out_char_code,
  output logic                          out_is_last,
  output logic [LEN_BITS-1:0]           out_text_length
);

  localparam int EFF    = (VALUE_BITS > VALUE_MAX) ? VALUE_MAX :
                          ((VALUE_BITS < VALUE_MIN) ? VALUE_MIN : VALUE_BITS);
  localparam int NCHUNK = (EFF + STEP_BITS - 1) / STEP_BITS;
  localparam int QW     = NCHUNK * STEP_BITS;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  typedef enum logic [1:0] {S_IDLE, S_DIVIDE, S_EMIT} state_t;

  state_t                state_r, state_nxt;
  radix_t                radix_r;
  radix_t                base_r, base_nxt;
  logic                  neg_r, neg_nxt;
  logic [QW-1:0]         work_r, work_nxt;
  digit_t                rem_r, rem_nxt;
  logic [CW-1:0]         chunk_r, chunk_nxt;
  len_t                  digit_count_r, digit_count_nxt;
  logic [IDX_BITS-1:0]   rd_idx_r, rd_idx_nxt;
  logic                  sign_pend_r, sign_pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  char_t                 out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  len_t                  out_len_r, out_len_nxt;
  logic                  store_we;
  digit_t                rd_digit_r;

  digit_t                digit_store [STORE_DEPTH];

  logic [EFF-1:0]        val_w;
  logic [EFF-1:0]        mag_w;
  logic                  neg_w;
  radix_t                base_w;
  logic [STEP_BITS-1:0]  quot_w;
  digit_t                rem_w;
  logic [QW-1:0]         work_shift_w;

  assign cfg_ready       = 1'b1;
  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_char_code   = out_char_r;
  assign out_is_last     = out_last_r;
  assign out_text_length = out_len_r;

  assign base_w = (radix_r < RADIX_MIN) ? RADIX_MIN :
                  ((radix_r > RADIX_MAX) ? RADIX_MAX : radix_r);
  assign val_w  = in_number[EFF-1:0];
  assign neg_w  = val_w[EFF-1] && (base_w == RADIX_DEC);
  assign mag_w  = neg_w ? EFF'(~val_w + 1'b1) : val_w;

  itoa_div_step u_div (
    .rem_in   (rem_r),
    .bits_in  (work_r[QW-1 -: STEP_BITS]),
    .divisor  (base_r),
    .quot_out (quot_w),
    .rem_out  (rem_w)
  );

  assign work_shift_w = QW'({work_r, quot_w});

  always_comb begin
    state_nxt       = state_r;
    base_nxt        = base_r;
    neg_nxt         = neg_r;
    work_nxt        = work_r;
    rem_nxt         = rem_r;
    chunk_nxt       = chunk_r;
    digit_count_nxt = digit_count_r;
    rd_idx_nxt      = rd_idx_r;
    sign_pend_nxt   = sign_pend_r;
    out_valid_nxt   = 1'b0;
    out_char_nxt    = out_char_r;
    out_last_nxt    = 1'b0;
    out_len_nxt     = out_len_r;
    store_we        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          base_nxt        = base_w;
          neg_nxt         = neg_w;
          work_nxt        = QW'(mag_w);
          rem_nxt         = '0;
          chunk_nxt       = '0;
          digit_count_nxt = '0;
          state_nxt       = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        work_nxt = work_shift_w;
        rem_nxt  = rem_w;
        if (chunk_r == CW'(NCHUNK - 1)) begin
          store_we        = 1'b1;
          chunk_nxt       = '0;
          rem_nxt         = '0;
          digit_count_nxt = digit_count_r + 1'b1;
          if ((work_shift_w == '0) || (digit_count_r == len_t'(STORE_DEPTH - 1))) begin
            rd_idx_nxt    = digit_count_r[IDX_BITS-1:0];
            sign_pend_nxt = neg_r;
            state_nxt     = S_EMIT;
          end
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        out_len_nxt   = digit_count_r + len_t'(neg_r);
        if (sign_pend_r) begin
          out_char_nxt  = CHAR_MINUS;
          sign_pend_nxt = 1'b0;
        end else begin
          out_char_nxt = char_of_digit(rd_digit_r);
          if (rd_idx_r == '0) begin
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      radix_r       <= RADIX_RESET;
      base_r        <= RADIX_DEC;
      neg_r         <= 1'b0;
      work_r        <= '0;
      rem_r         <= '0;
      chunk_r       <= '0;
      digit_count_r <= '0;
      rd_idx_r      <= '0;
      sign_pend_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      out_char_r    <= '0;
      out_last_r    <= 1'b0;
      out_len_r     <= '0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        radix_r <= cfg_radix;
      end
      base_r        <= base_nxt;
      neg_r         <= neg_nxt;
      work_r        <= work_nxt;
      rem_r         <= rem_nxt;
      chunk_r       <= chunk_nxt;
      digit_count_r <= digit_count_nxt;
      rd_idx_r      <= rd_idx_nxt;
      sign_pend_r   <= sign_pend_nxt;
      out_valid_r   <= out_valid_nxt;
      out_char_r    <= out_char_nxt;
      out_last_r    <= out_last_nxt;
      out_len_r     <= out_len_nxt;
    end
  end

  // registered read follows rd_idx_r, with the digit being written passed through
  always_ff @(posedge clk) begin
    if (store_we) begin
      digit_store[digit_count_r[IDX_BITS-1:0]] <= rem_w;
    end
    if (store_we && (digit_count_r[IDX_BITS-1:0] == rd_idx_nxt)) begin
      rd_digit_r <= rem_w;
    end else begin
      rd_digit_r <= digit_store[rd_idx_nxt];
    end
  end

  `ITOA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `ITOA_ASSERT_NOW(a_mid_busy, out_valid && !out_is_last, busy, "result before last while idle")
  `ITOA_ASSERT_NEXT(a_last_gap, out_valid && out_is_last, !out_valid, "result after last character")
  `ITOA_ASSERT_NOW(a_len_range, out_valid,
                   (out_text_length != '0) && (out_text_length <= len_t'(STORE_DEPTH)),
                   "text length out of range")

endmodule

// ----- bench/integer_to_digit_string_tb.sv -----
// testbench for the integer to ascii digit string converter
`timescale 1ns / 1ps

module integer_to_digit_string_tb
  import itoa_pkg::*;
;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_NUMBERS = 20;

  typedef struct packed {
    char_t code;
    logic  last;
    len_t  text_len;
  } char_expect_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [RADIX_BITS-1:0]         cfg_radix;
  logic                          start;
  logic                          busy;
  logic signed [NUMBER_BITS-1:0] in_number;
  logic                          out_valid;
  logic [CHAR_BITS-1:0]          out_char_code;
  logic                          out_is_last;
  logic [LEN_BITS-1:0]           out_text_length;

  char_expect_t expected_chars[$];
  radix_t radix_shadow;
  int mismatch_count;
  int chars_checked;
  int numbers_sent;
  int radix_writes;
  int idle_cycles;
  bit no_idle;

  integer_to_digit_string DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_radix      (cfg_radix),
    .start          (start),
    .busy           (busy),
    .in_number      (in_number),
    .out_valid      (out_valid),
    .out_char_code  (out_char_code),
    .out_is_last    (out_is_last),
    .out_text_length(out_text_length)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // queue up the characters one number should produce under the current radix
  function automatic void spell_number(input logic [NUMBER_BITS-1:0] number);
    int unsigned base;
    logic negative;
    logic [NUMBER_BITS-1:0] magnitude;
    digit_t digits[$];
    len_t text_len;
    char_expect_t item;
    base = radix_shadow;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    negative = number[NUMBER_BITS-1] && (base == RADIX_DEC);
    magnitude = negative ? -number : number;
    do begin
      digits.push_front(digit_t'(magnitude % base));
      magnitude = magnitude / base;
    end while (magnitude != 0);
    text_len = len_t'(digits.size() + int'(negative));
    if (negative) begin
      item.code = CHAR_MINUS;
      item.last = 1'b0;
      item.text_len = text_len;
      expected_chars.push_back(item);
    end
    foreach (digits[i]) begin
      if (digits[i] < DIGIT_TEN) begin
        item.code = char_t'(CHAR_ZERO + digits[i]);
      end else begin
        item.code = char_t'(CHAR_UPPER + (digits[i] - DIGIT_TEN));
      end
      item.last = (i == digits.size() - 1);
      item.text_len = text_len;
      expected_chars.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    char_expect_t want;
    if (!rst_n) begin
      radix_shadow = RADIX_RESET;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (out_valid) begin
        idle_cycles = 0;
        chars_checked++;
        if (expected_chars.size() == 0) begin
          $error("unexpected character transaction: char_code %h", out_char_code);
          mismatch_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char_code !== want.code) begin
            $error("char_code: expected %h, got %h", want.code, out_char_code);
            mismatch_count++;
          end
          if (out_is_last !== want.last) begin
            $error("is_last: expected %b, got %b", want.last, out_is_last);
            mismatch_count++;
          end
          if (out_text_length !== want.text_len) begin
            $error("text_length: expected %0d, got %0d", want.text_len, out_text_length);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        radix_shadow = cfg_radix;
        radix_writes++;
        idle_cycles = 0;
      end
      if (start && !busy) begin
        spell_number(in_number);
        numbers_sent++;
        idle_cycles = 0;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_number(input logic [NUMBER_BITS-1:0] number);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_all_chars();
    start <= 1'b0;
    @(posedge clk);
    while (busy || (expected_chars.size() != 0)) @(posedge clk);
  endtask

  task automatic write_radix(input radix_t value);
    wait_all_chars();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_radix <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [NUMBER_BITS-1:0] pick_number();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 40);
      1: return -$urandom_range(1, 40);
      2: return $urandom >> $urandom_range(0, 31);
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_decimal_signs();
    send_number(32'd0);
    send_number(32'd1);
    send_number(-32'sd1);
    send_number(32'd9);
    send_number(32'd10);
    send_number(-32'sd10);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(-32'sd987654321);
  endtask

  task automatic test_hex_letters();
    write_radix(RADIX_MAX);
    send_number(32'hFEDC_BA98);
    send_number(32'h0123_4567);
    send_number(32'h8000_0000);
    send_number(32'h0);
  endtask

  task automatic test_binary();
    write_radix(RADIX_MIN);
    send_number(32'hFFFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'h1);
  endtask

  task automatic test_clamped_radix();
    write_radix(radix_t'(0));
    send_number(32'hAAAA_AAAA);
    write_radix(radix_t'(1));
    send_number(32'd5);
    write_radix(radix_t'(17));
    send_number(32'hDEAD_BEEF);
    write_radix(radix_t'(31));
    send_number(-32'sd1);
  endtask

  task automatic test_random_numbers();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if ($urandom_range(0, 3) == 0) begin
        write_radix(RADIX_DEC);
      end else begin
        write_radix(radix_t'($urandom_range(0, 31)));
      end
      no_idle = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_NUMBERS; n++) begin
        send_number(pick_number());
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_radix <= '0;
    start <= 1'b0;
    in_number <= '0;
    mismatch_count = 0;
    chars_checked = 0;
    numbers_sent = 0;
    radix_writes = 0;
    no_idle = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_decimal_signs();
    test_hex_letters();
    test_binary();
    test_clamped_radix();
    test_random_numbers();

    wait_all_chars();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $error("%0d characters never arrived", expected_chars.size());
      mismatch_count++;
    end
    $display("converted %0d numbers into %0d characters across %0d radix writes",
             numbers_sent, chars_checked, radix_writes);
    $display("radix settings included clamped, binary, decimal and hex; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/itoa_pkg.sv
design/itoa_div_step.sv
design/integer_to_digit_string.sv
bench/integer_to_digit_string_tb.sv
